[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the credit allocator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/wca_pkg.sv]
// Types, constants and codes of the weighted credit allocator.
// No dependencies; used by the divider, the top level and the testbench.
`timescale 1ns / 1ps

package wca_pkg;

   localparam int FLOWS     = 64;
   localparam int FLOW_W    = $clog2(FLOWS);
   localparam int LEN_W     = $clog2(FLOWS + 1);
   localparam int CREDIT_W  = 32;
   localparam int PCT_W     = 7;
   localparam int WSUM_W    = 38;
   localparam int PROD_W    = 2 * CREDIT_W;
   localparam int DIV_STEPS = PROD_W;

   localparam logic [PCT_W-1:0]    PCT_FULL   = 7'd100;
   localparam logic [CREDIT_W-1:0] CPP_RESET  = 32'd100000;

   // Reciprocal of one hundred: floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT
   // for every 32-bit x.
   localparam logic [CREDIT_W-1:0] RECIP_100   = 32'h51EB_851F;
   localparam int                  RECIP_SHIFT = 37;

   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_PAY    = 3'd1,
      CMD_ADD    = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_SETW   = 3'd4,
      CMD_SETMIN = 3'd5,
      CMD_SETMAX = 3'd6,
      CMD_READ   = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_REFUSED  = 2'd1,
      STAT_INACTIVE = 2'd2
   } status_type;

   typedef struct packed {
      logic [CREDIT_W-1:0] credit;
      logic [CREDIT_W-1:0] weight;
      logic [PCT_W-1:0]    min_pct;
      logic [PCT_W-1:0]    max_pct;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [WSUM_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quotient;
      logic [WSUM_W-1:0] remainder;
   } div_rsp_type;

endpackage

[sv/wca_ram.sv]
// Generic simple dual-port RAM with a registered read port.
// No dependencies; instantiated by the top level.
`timescale 1ns / 1ps

module wca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/wca_div.sv]
// Restoring divider, one quotient bit per cycle, for the credit allocator.
// Depends on wca_pkg for the widths and the request and response types.
`timescale 1ns / 1ps

module wca_div (
   input  logic                 clock,
   input  logic                 reset,
   input  wca_pkg::div_req_type div_req,
   output wca_pkg::div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(wca_pkg::DIV_STEPS);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [wca_pkg::PROD_W-1:0]  num_ff, num_in;
   logic [wca_pkg::WSUM_W-1:0]  rem_ff, rem_in;
   logic [wca_pkg::WSUM_W-1:0]  den_ff, den_in;
   logic [wca_pkg::WSUM_W+1:0]  diff;
   logic [wca_pkg::WSUM_W:0]    shifted;

   always_comb begin
      shifted = {rem_ff, num_ff[wca_pkg::PROD_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits its width.
         if (!diff[wca_pkg::WSUM_W+1]) begin
            rem_in = diff[wca_pkg::WSUM_W-1:0];
            num_in = {num_ff[wca_pkg::PROD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[wca_pkg::WSUM_W-1:0];
            num_in = {num_ff[wca_pkg::PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(wca_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = num_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[sv/weighted_credit_allocator.sv]
// Weighted credit allocator top level; uses wca_pkg, wca_ram, wca_div, assert_macros.svh.
// Pay, read, set and refused commands load the registered response from the execute
// state when the output is free; add and remove walk the order list; a tick walks the
// list, using the 64-step divider per flow and moving each clamped flow to the front,
// or returns the pool without a walk when no flow is listed or the weight sum is zero.
// One request is in work at a time. Reset (synchronous, active high) clears all tables.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module weighted_credit_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [5:0]  req_flow,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_credit,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int CW = wca_pkg::CREDIT_W;
   localparam int FW = wca_pkg::FLOW_W;
   localparam int LW = wca_pkg::LEN_W;
   localparam int SW = wca_pkg::WSUM_W;
   localparam int PW = wca_pkg::PCT_W;

   // One-hot sequencer. Simple commands go IDLE -> EXEC -> IDLE, or through FIN while the
   // output is held. Add and clamped tick flows use the SH_* states to shift the order list
   // right by one entry; remove compacts the list in the RM_* states; a tick walks the list
   // through the T_* states.
   typedef enum logic [18:0] {
      ST_IDLE    = 19'b0000000000000000001,
      ST_EXEC    = 19'b0000000000000000010,
      ST_FIN     = 19'b0000000000000000100,
      ST_SH_RD   = 19'b0000000000000001000,
      ST_SH_WR   = 19'b0000000000000010000,
      ST_SH_FRNT = 19'b0000000000000100000,
      ST_RM_RD   = 19'b0000000000001000000,
      ST_RM_WR   = 19'b0000000000010000000,
      ST_T_START = 19'b0000000000100000000,
      ST_T_UNIT  = 19'b0000000001000000000,
      ST_T_RD    = 19'b0000000010000000000,
      ST_T_FLOW  = 19'b0000000100000000000,
      ST_T_ENT   = 19'b0000001000000000000,
      ST_T_MIN   = 19'b0000010000000000000,
      ST_T_MAX   = 19'b0000100000000000000,
      ST_T_PROD  = 19'b0001000000000000000,
      ST_T_DIVS  = 19'b0010000000000000000,
      ST_T_DIVW  = 19'b0100000000000000000,
      ST_T_UPD   = 19'b1000000000000000000
   } state_type;

   state_type state_ff, state_in;

   // Request registers.
   wca_pkg::cmd_type     cmd_ff;
   logic [FW-1:0]        ent_f_ff, ent_f_in;
   logic [CW-1:0]        value_ff;

   // Architectural state held in flip-flops.
   logic [CW-1:0]              cpp_ff;
   logic [wca_pkg::FLOWS-1:0]  active_ff, active_in;
   logic [wca_pkg::FLOWS-1:0]  written_ff, written_in;
   logic [LW-1:0]              len_ff, len_in;
   logic [SW-1:0]              wsum_ff, wsum_in;
   logic [CW-1:0]              pool_ff, pool_in;

   // Walk state of the tick and the list updates.
   logic [CW-1:0]  budget_ff, budget_in;
   logic [CW-1:0]  left_ff, left_in;
   logic [CW-1:0]  unit_ff, unit_in;
   logic [LW-1:0]  pos_ff, pos_in;
   logic [LW-1:0]  j_ff, j_in;
   logic [LW-1:0]  sh_k_ff, sh_k_in;
   logic           sh_tick_ff, sh_tick_in;

   // Per-flow tick working registers.
   logic [CW-1:0]              e_old_ff, e_old_in;
   logic [CW-1:0]              e_w_ff, e_w_in;
   logic [PW-1:0]              e_min_ff, e_min_in;
   logic [PW-1:0]              e_max_ff, e_max_in;
   logic [wca_pkg::PROD_W-1:0] mul_ff, mul_in;
   logic [CW-1:0]              minc_ff, minc_in;
   logic [CW-1:0]              maxc_ff, maxc_in;
   logic [CW-1:0]              fair_ff, fair_in;
   logic [CW-1:0]              cur_ff, cur_in;

   // Pending response and the output register.
   wca_pkg::status_type  res_status_ff, res_status_in;
   logic [CW-1:0]        res_credit_ff, res_credit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   wca_pkg::status_type  rsp_status_ff;
   logic [CW-1:0]        rsp_credit_ff;
   logic                 out_load;
   logic                 out_free;

   // Memories: one entry per flow, and the order list.
   logic                  ent_we;
   logic [FW-1:0]         ent_raddr;
   wca_pkg::entry_type    ent_wd;
   logic [wca_pkg::ENTRY_W-1:0] ent_rd_raw;
   wca_pkg::entry_type    ent_rd;
   wca_pkg::entry_type    e;
   logic                  ord_we;
   logic [FW-1:0]         ord_waddr;
   logic [FW-1:0]         ord_wdata;
   logic [FW-1:0]         ord_raddr;
   logic [FW-1:0]         ord_rdata;

   // Shared multiplier and divider.
   logic [CW-1:0]         mul_a, mul_b;
   wca_pkg::div_req_type  div_req;
   wca_pkg::div_rsp_type  div_rsp;

   // Combinational helpers.
   logic                  act;
   logic [PW-1:0]         pct;
   logic [CW:0]           fair_sum;
   logic [wca_pkg::PROD_W:0] q_up;
   logic [CW-1:0]         fair_c;
   logic [CW-1:0]         dlt;
   logic [CW-1:0]         new_credit;
   logic                  clamp;

   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CW] ? '1 : s[CW-1:0];
   endfunction

   wca_ram #(.WIDTH(wca_pkg::ENTRY_W), .DEPTH(wca_pkg::FLOWS)) u_ent_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_f_ff),
      .wdata (ent_wd),
      .raddr (ent_raddr),
      .rdata (ent_rd_raw)
   );

   wca_ram #(.WIDTH(FW), .DEPTH(wca_pkg::FLOWS)) u_ord_ram (
      .clock (clock),
      .we    (ord_we),
      .waddr (ord_waddr),
      .wdata (ord_wdata),
      .raddr (ord_raddr),
      .rdata (ord_rdata)
   );

   wca_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ent_rd    = wca_pkg::entry_type'(ent_rd_raw);

   // An entry that was never written reads as all zero.
   assign e   = written_ff[ent_f_ff] ? ent_rd : '0;
   assign act = active_ff[ent_f_ff];
   assign pct = (value_ff > CW'(wca_pkg::PCT_FULL)) ? wca_pkg::PCT_FULL : value_ff[PW-1:0];

   // The entry RAM is addressed from the request port while idle, so its data
   // is ready in the execute cycle that follows acceptance.
   always_comb begin
      case (state_ff)
         ST_IDLE:   ent_raddr = req_flow;
         ST_T_FLOW: ent_raddr = ord_rdata;
         default:   ent_raddr = ent_f_ff;
      endcase
   end

   // Rounded-up share from the divider, saturated to the credit width.
   always_comb begin
      q_up     = {1'b0, div_rsp.quotient} +
                 {{wca_pkg::PROD_W{1'b0}}, (div_rsp.remainder != '0)};
      fair_c   = (q_up[wca_pkg::PROD_W:CW] != '0) ? '1 : q_up[CW-1:0];
      fair_sum = {1'b0, e_old_ff} + {1'b0, fair_c};
   end

   always_comb begin
      state_in      = state_ff;
      ent_f_in      = ent_f_ff;
      active_in     = active_ff;
      written_in    = written_ff;
      len_in        = len_ff;
      wsum_in       = wsum_ff;
      pool_in       = pool_ff;
      budget_in     = budget_ff;
      left_in       = left_ff;
      unit_in       = unit_ff;
      pos_in        = pos_ff;
      j_in          = j_ff;
      sh_k_in       = sh_k_ff;
      sh_tick_in    = sh_tick_ff;
      e_old_in      = e_old_ff;
      e_w_in        = e_w_ff;
      e_min_in      = e_min_ff;
      e_max_in      = e_max_ff;
      mul_in        = mul_ff;
      minc_in       = minc_ff;
      maxc_in       = maxc_ff;
      fair_in       = fair_ff;
      cur_in        = cur_ff;
      res_status_in = res_status_ff;
      res_credit_in = res_credit_ff;
      out_load      = 1'b0;
      ent_we        = 1'b0;
      ent_wd        = e;
      ord_we        = 1'b0;
      ord_waddr     = '0;
      ord_wdata     = ent_f_ff;
      ord_raddr     = pos_ff[FW-1:0];
      mul_a         = unit_ff;
      mul_b         = '0;
      div_req       = '0;
      dlt           = '0;
      new_credit    = cur_ff;
      clamp         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ent_f_in = req_flow;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            // Default response: status ok with the stored credit.
            res_status_in = wca_pkg::STAT_OK;
            res_credit_in = e.credit;
            state_in      = ST_FIN;
            case (cmd_ff)
               wca_pkg::CMD_TICK: begin
                  state_in = ST_T_START;
               end
               wca_pkg::CMD_ADD: begin
                  if (act) begin
                     res_status_in = wca_pkg::STAT_INACTIVE;
                  end else begin
                     ent_we               = 1'b1;
                     ent_wd               = '0;
                     ent_wd.weight        = value_ff;
                     active_in[ent_f_ff]  = 1'b1;
                     written_in[ent_f_ff] = 1'b1;
                     wsum_in              = wsum_ff + SW'(value_ff);
                     res_credit_in        = '0;
                     sh_k_in              = len_ff;
                     sh_tick_in           = 1'b0;
                     state_in             = ST_SH_RD;
                  end
               end
               default: begin
                  if (!act) begin
                     res_status_in = wca_pkg::STAT_INACTIVE;
                  end else begin
                     case (cmd_ff)
                        wca_pkg::CMD_PAY: begin
                           if (e.credit != '0) begin
                              if (e.credit < value_ff) begin
                                 res_status_in = wca_pkg::STAT_REFUSED;
                              end else begin
                                 ent_we        = 1'b1;
                                 ent_wd.credit = e.credit - value_ff;
                                 res_credit_in = e.credit - value_ff;
                              end
                           end
                        end
                        wca_pkg::CMD_REMOVE: begin
                           wsum_in             = wsum_ff - SW'(e.weight);
                           active_in[ent_f_ff] = 1'b0;
                           pos_in              = '0;
                           j_in                = '0;
                           state_in            = ST_RM_RD;
                        end
                        wca_pkg::CMD_SETW: begin
                           wsum_in       = wsum_ff - SW'(e.weight) + SW'(value_ff);
                           ent_we        = 1'b1;
                           ent_wd.weight = value_ff;
                        end
                        wca_pkg::CMD_SETMIN: begin
                           ent_we         = 1'b1;
                           ent_wd.min_pct = pct;
                        end
                        wca_pkg::CMD_SETMAX: begin
                           ent_we         = 1'b1;
                           ent_wd.max_pct = pct;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            endcase
            // Commands that finish here go straight to the output register when it is free.
            if (state_in == ST_FIN && out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_FIN: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_SH_RD: begin
            ord_raddr = sh_k_ff[FW-1:0] - 1'b1;
            state_in  = (sh_k_ff == '0) ? ST_SH_FRNT : ST_SH_WR;
         end

         ST_SH_WR: begin
            ord_we    = 1'b1;
            ord_waddr = sh_k_ff[FW-1:0];
            ord_wdata = ord_rdata;
            sh_k_in   = sh_k_ff - 1'b1;
            state_in  = ST_SH_RD;
         end

         ST_SH_FRNT: begin
            ord_we    = 1'b1;
            ord_waddr = '0;
            ord_wdata = ent_f_ff;
            if (sh_tick_ff) begin
               pos_in   = pos_ff + 1'b1;
               state_in = ST_T_RD;
            end else begin
               len_in   = len_ff + 1'b1;
               state_in = ST_FIN;
            end
         end

         ST_RM_RD: begin
            if (pos_ff == len_ff) begin
               len_in   = j_ff;
               state_in = ST_FIN;
            end else begin
               ord_raddr = pos_ff[FW-1:0];
               state_in  = ST_RM_WR;
            end
         end

         ST_RM_WR: begin
            // Every entry other than the removed flow slides down to slot j.
            if (ord_rdata != ent_f_ff) begin
               ord_we    = 1'b1;
               ord_waddr = j_ff[FW-1:0];
               ord_wdata = ord_rdata;
               j_in      = j_ff + 1'b1;
            end
            pos_in   = pos_ff + 1'b1;
            state_in = ST_RM_RD;
         end

         ST_T_START: begin
            if (len_ff == '0 || wsum_ff == '0) begin
               res_status_in = wca_pkg::STAT_OK;
               res_credit_in = pool_ff;
               state_in      = ST_FIN;
            end else begin
               budget_in = sat_add(cpp_ff, pool_ff);
               left_in   = '0;
               pos_in    = '0;
               // The clamp unit is the period budget divided by one hundred,
               // taken as a multiplication by the scaled reciprocal.
               mul_a     = cpp_ff;
               mul_b     = wca_pkg::RECIP_100;
               mul_in    = mul_a * mul_b;
               state_in  = ST_T_UNIT;
            end
         end

         ST_T_UNIT: begin
            unit_in  = CW'(mul_ff[wca_pkg::PROD_W-1:wca_pkg::RECIP_SHIFT]);
            state_in = ST_T_RD;
         end

         ST_T_RD: begin
            if (pos_ff == len_ff) begin
               pool_in       = left_ff;
               res_status_in = wca_pkg::STAT_OK;
               res_credit_in = left_ff;
               state_in      = ST_FIN;
            end else begin
               ord_raddr = pos_ff[FW-1:0];
               state_in  = ST_T_FLOW;
            end
         end

         ST_T_FLOW: begin
            ent_f_in = ord_rdata;
            state_in = ST_T_ENT;
         end

         ST_T_ENT: begin
            e_old_in = e.credit;
            e_w_in   = e.weight;
            e_min_in = e.min_pct;
            e_max_in = e.max_pct;
            state_in = ST_T_MIN;
         end

         ST_T_MIN: begin
            mul_a    = unit_ff;
            mul_b    = CW'(e_min_ff);
            mul_in   = mul_a * mul_b;
            state_in = ST_T_MAX;
         end

         ST_T_MAX: begin
            // The unit is at most a hundredth of the budget, so levels fit.
            minc_in  = mul_ff[CW-1:0];
            mul_a    = unit_ff;
            mul_b    = CW'(e_max_ff);
            mul_in   = mul_a * mul_b;
            state_in = ST_T_PROD;
         end

         ST_T_PROD: begin
            maxc_in  = mul_ff[CW-1:0];
            mul_a    = budget_ff;
            mul_b    = e_w_ff;
            mul_in   = mul_a * mul_b;
            state_in = ST_T_DIVS;
         end

         ST_T_DIVS: begin
            div_req.start    = 1'b1;
            div_req.dividend = mul_ff;
            div_req.divisor  = wsum_ff;
            state_in         = ST_T_DIVW;
         end

         ST_T_DIVW: begin
            if (div_rsp.done) begin
               fair_in  = fair_c;
               cur_in   = fair_sum[CW] ? '1 : fair_sum[CW-1:0];
               state_in = ST_T_UPD;
            end
         end

         ST_T_UPD: begin
            ent_we         = 1'b1;
            ent_wd.weight  = e_w_ff;
            ent_wd.min_pct = e_min_ff;
            ent_wd.max_pct = e_max_ff;
            if (e_min_ff != '0 || e_max_ff != '0) begin
               new_credit = cur_ff;
               if (e_min_ff != '0 && cur_ff < minc_ff) begin
                  dlt        = minc_ff - cur_ff;
                  budget_in  = (budget_ff > dlt) ? budget_ff - dlt : '0;
                  new_credit = minc_ff;
                  clamp      = 1'b1;
               end else if (e_max_ff != '0 && cur_ff > maxc_ff) begin
                  dlt        = cur_ff - maxc_ff;
                  budget_in  = sat_add(budget_ff, dlt);
                  new_credit = maxc_ff;
                  clamp      = 1'b1;
               end
            end else begin
               // Flows with no minimum or maximum return their old credit to the pool.
               left_in    = sat_add(left_ff, cur_ff - fair_ff);
               new_credit = fair_ff;
            end
            ent_wd.credit = new_credit;
            if (clamp) begin
               sh_k_in    = pos_ff;
               sh_tick_in = 1'b1;
               state_in   = ST_SH_RD;
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = ST_T_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cpp_ff       <= wca_pkg::CPP_RESET;
         active_ff    <= '0;
         written_ff   <= '0;
         len_ff       <= '0;
         wsum_ff      <= '0;
         pool_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            cpp_ff <= csr_wr_data;
         end
         active_ff    <= active_in;
         written_ff   <= written_in;
         len_ff       <= len_in;
         wsum_ff      <= wsum_in;
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (state_ff == ST_IDLE && req_valid) begin
         cmd_ff   <= wca_pkg::cmd_type'(req_command);
         value_ff <= req_value;
      end
      ent_f_ff      <= ent_f_in;
      budget_ff     <= budget_in;
      left_ff       <= left_in;
      unit_ff       <= unit_in;
      pos_ff        <= pos_in;
      j_ff          <= j_in;
      sh_k_ff       <= sh_k_in;
      sh_tick_ff    <= sh_tick_in;
      e_old_ff      <= e_old_in;
      e_w_ff        <= e_w_in;
      e_min_ff      <= e_min_in;
      e_max_ff      <= e_max_in;
      mul_ff        <= mul_in;
      minc_ff       <= minc_in;
      maxc_ff       <= maxc_in;
      fair_ff       <= fair_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_credit_ff <= res_credit_in;
      if (out_load) begin
         rsp_status_ff <= res_status_in;
         rsp_credit_ff <= res_credit_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_credit = rsp_credit_ff;

   // An accepted request always enters the execute cycle next.
   `ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && req_ready, state_ff == ST_EXEC)
   // Between requests the order list is as long as the number of active flows.
   `ASSERT_SAME(a_len_active, clock, reset, state_ff == ST_IDLE,
                {25'd0, len_ff} == $countones(active_ff))
   // An active flow always has a written table entry.
   `ASSERT_SAME(a_active_written, clock, reset, 1'b1, (active_ff & ~written_ff) == '0)

endmodule

[tb/testbench.sv]
// Self-checking testbench of the weighted credit allocator (weighted_credit_allocator).
// It depends on wca_pkg for the command and status codes; a built-in predictor supplies
// the expected response of every request, checked field by field as responses come out.
`timescale 1ns / 1ps

module testbench;
   import wca_pkg::*;

   // No single request comes anywhere near this limit. The longest is a tick that walks
   // the whole order list, clamping some of its flows.
   localparam int STALL_LIMIT = 40000;
   // How long the receiver holds its ready low in the back-pressure test.
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      status_type  status;
      logic [31:0] credit;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_command = '0;
   logic [5:0]  req_flow = '0;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_credit;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   weighted_credit_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_flow(req_flow), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_credit(rsp_credit),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The predictor keeps its own copy of every table of the block.
   logic [31:0] budget_per_tick;
   logic [31:0] flow_credit [FLOWS];
   logic [31:0] flow_weight [FLOWS];
   int unsigned flow_min_pct [FLOWS];
   int unsigned flow_max_pct [FLOWS];
   bit          flow_active [FLOWS];
   int unsigned service_order [FLOWS];
   int unsigned order_len;
   longint unsigned weight_sum_model;
   logic [31:0] leftover_pool;

   outcome_type pending_outcomes [$];
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_go = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   function automatic logic [31:0] clip32(longint unsigned sum);
      return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   // Applies one request to the predicted state and returns the response it must give.
   function automatic outcome_type allocator_predict(cmd_type cmd, int unsigned f,
                                                     logic [31:0] v);
      outcome_type     r;
      longint unsigned budget, left, prod, fair64, unit, cur, minc, maxc, d;
      int unsigned     g, i, j, kept, pct, head;
      bit              moved;
      r.status = STAT_OK;
      pct = (v > 100) ? 100 : v;
      if (cmd == CMD_TICK) begin
         if (order_len != 0 && weight_sum_model != 0) begin
            budget = clip32(longint'(budget_per_tick) + leftover_pool);
            left = 0;
            unit = budget_per_tick / 100;
            for (i = 0; i < order_len; i++) begin
               g = service_order[i];
               prod = budget * flow_weight[g];
               fair64 = prod / weight_sum_model +
                        (((prod % weight_sum_model) != 0) ? 1 : 0);
               cur = clip32(longint'(flow_credit[g]) + clip32(fair64));
               if (flow_min_pct[g] != 0 || flow_max_pct[g] != 0) begin
                  minc = unit * flow_min_pct[g];
                  maxc = unit * flow_max_pct[g];
                  moved = 1'b0;
                  if (flow_min_pct[g] != 0 && cur < minc) begin
                     d = minc - cur;
                     budget = (budget > d) ? budget - d : 0;
                     cur = minc;
                     moved = 1'b1;
                  end else if (flow_max_pct[g] != 0 && cur > maxc) begin
                     budget = clip32(budget + (cur - maxc));
                     cur = maxc;
                     moved = 1'b1;
                  end
                  // A clamped flow jumps to the front; the walk then goes on with the
                  // flow that followed it.
                  if (moved) begin
                     head = service_order[i];
                     for (j = i; j > 0; j--) service_order[j] = service_order[j-1];
                     service_order[0] = head;
                  end
                  flow_credit[g] = cur;
               end else begin
                  left = clip32(left + (cur - clip32(fair64)));
                  flow_credit[g] = clip32(fair64);
               end
            end
            leftover_pool = left;
         end
         r.credit = leftover_pool;
         return r;
      end
      if (cmd == CMD_ADD) begin
         if (flow_active[f]) begin
            r.status = STAT_INACTIVE;
         end else begin
            for (i = order_len; i > 0; i--) service_order[i] = service_order[i-1];
            service_order[0] = f;
            order_len++;
            flow_active[f] = 1'b1;
            flow_weight[f] = v;
            flow_min_pct[f] = 0;
            flow_max_pct[f] = 0;
            flow_credit[f] = '0;
            weight_sum_model += v;
         end
      end else if (!flow_active[f]) begin
         r.status = STAT_INACTIVE;
      end else begin
         case (cmd)
            CMD_PAY: begin
               // A flow holding no credit pays nothing and is never refused.
               if (flow_credit[f] != 0) begin
                  if (flow_credit[f] < v) r.status = STAT_REFUSED;
                  else flow_credit[f] = flow_credit[f] - v;
               end
            end
            CMD_REMOVE: begin
               kept = 0;
               for (i = 0; i < order_len; i++) begin
                  if (service_order[i] != f) begin
                     service_order[kept] = service_order[i];
                     kept++;
                  end
               end
               order_len = kept;
               weight_sum_model -= flow_weight[f];
               flow_active[f] = 1'b0;
            end
            CMD_SETW: begin
               weight_sum_model = weight_sum_model - flow_weight[f] + v;
               flow_weight[f] = v;
            end
            CMD_SETMIN: flow_min_pct[f] = pct;
            CMD_SETMAX: flow_max_pct[f] = pct;
            default: ;
         endcase
      end
      r.credit = flow_credit[f];
      return r;
   endfunction

   // Offers one request, holding it until accepted, and records what it must return.
   // The valid is lowered only when an idle gap comes first, so it never gets two
   // assignments in one time step.
   task automatic send_request(cmd_type cmd, int unsigned f, logic [31:0] v);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_flow    <= f[5:0];
      req_value   <= v;
      do @(posedge clock); while (!req_ready);
      pending_outcomes.push_back(allocator_predict(cmd, f, v));
   endtask

   // Stops offering and waits until every outstanding response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // The block is idle here, so the budget register can change safely.
   task automatic write_budget(logic [31:0] amount);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= amount;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      budget_per_tick = amount;
   endtask

   function automatic int unsigned pick_flow();
      if (order_len != 0 && $urandom_range(99) < 80)
         return service_order[$urandom_range(order_len - 1)];
      return $urandom_range(FLOWS - 1);
   endfunction

   function automatic logic [31:0] pick_weight();
      case ($urandom_range(9))
         0: return '0;
         1: return $urandom();
         2: return 32'hFFFF_FFFF;
         default: return $urandom_range(1, 1000);
      endcase
   endfunction

   function automatic logic [31:0] pick_percent();
      case ($urandom_range(9))
         0: return $urandom();
         1: return '0;
         2: return 100;
         default: return $urandom_range(0, 120);
      endcase
   endfunction

   // Mostly payments that fit the credit, with refusals, exact payments and noise mixed in.
   function automatic logic [31:0] pick_packet(int unsigned f);
      logic [31:0] c;
      c = flow_credit[f];
      case ($urandom_range(9))
         0: return $urandom();
         1: return c;
         2: return (c == 32'hFFFF_FFFF) ? c : c + 1;
         3: return '0;
         default: return (c == 0) ? $urandom_range(1, 1500) : $urandom_range(0, c);
      endcase
   endfunction

   // One random request; the flow count drifts but is pulled back when it gets large.
   task automatic send_random_request();
      int unsigned roll, f;
      roll = $urandom_range(99);
      f = pick_flow();
      if (roll < 7)
         send_request(CMD_TICK, $urandom_range(FLOWS - 1), $urandom());
      else if (roll < 45)
         send_request(CMD_PAY, f, pick_packet(f));
      else if (roll < 57 && order_len < 40)
         send_request(CMD_ADD, $urandom_range(FLOWS - 1), pick_weight());
      else if (roll < 64)
         send_request(CMD_REMOVE, f, $urandom());
      else if (roll < 72)
         send_request(CMD_SETW, f, pick_weight());
      else if (roll < 80)
         send_request(CMD_SETMIN, f, pick_percent());
      else if (roll < 88)
         send_request(CMD_SETMAX, f, pick_percent());
      else
         send_request(CMD_READ, f, $urandom());
   endtask

   // Idle block, inactive flows, extreme weights, duplicate add, refusals, zero-credit
   // payment, percent saturation, clamping and removal.
   task automatic test_directed_cases();
      send_request(CMD_TICK, 0, '0);
      send_request(CMD_READ, 5, '0);
      send_request(CMD_PAY, 5, 32'd10);
      send_request(CMD_REMOVE, 5, '0);
      send_request(CMD_SETW, 5, 32'd3);
      send_request(CMD_ADD, 0, 32'd0);
      send_request(CMD_TICK, 0, '0);
      send_request(CMD_PAY, 0, 32'hFFFF_FFFF);
      send_request(CMD_ADD, 63, 32'hFFFF_FFFF);
      send_request(CMD_ADD, 63, 32'd1);
      send_request(CMD_ADD, 42, 32'd1);
      send_request(CMD_SETMIN, 42, 32'd250);
      send_request(CMD_SETMAX, 63, 32'd30);
      send_request(CMD_TICK, 0, '0);
      send_request(CMD_PAY, 42, 32'hFFFF_FFFF);
      send_request(CMD_PAY, 63, flow_credit[63]);
      send_request(CMD_PAY, 63, 32'd7);
      send_request(CMD_SETMIN, 42, 32'hFFFF_FFFF);
      send_request(CMD_SETMAX, 42, 32'd1);
      send_request(CMD_SETW, 0, 32'd5);
      send_request(CMD_TICK, 0, '0);
      send_request(CMD_READ, 0, '0);
      send_request(CMD_REMOVE, 42, '0);
      send_request(CMD_TICK, 0, '0);
      wait_drained();
   endtask

   // Random traffic under every budget extreme and every idling pattern.
   task automatic test_budget_and_idling();
      logic [31:0] budgets [6];
      int          send_pcts [4];
      int          stall_pcts [4];
      budgets    = '{32'd0, 32'hFFFF_FFFF, 32'd100000, 32'd99, 32'd12345, 32'd0};
      send_pcts  = '{0, 61, 0, 13};
      stall_pcts = '{0, 0, 61, 13};
      budgets[5] = $urandom();
      for (int m = 0; m < 4; m++) begin
         for (int b = 0; b < 6; b++) begin
            write_budget(budgets[b]);
            send_idle_pct  = send_pcts[m];
            recv_stall_pct = stall_pcts[m];
            repeat (70) send_random_request();
            wait_drained();
         end
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   // The receiver holds off for a long stretch while requests keep coming, so the
   // block backs up and stops taking requests; then the sender waits for the drain.
   task automatic test_backpressure();
      write_budget(32'd100000);
      hold_go = 1'b1;
      repeat (12) send_random_request();
      wait_drained();
   endtask

   // Receiver side: random stalls, or a long counted hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_go) begin
         hold_go = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Each accepted response is matched against the oldest prediction.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response with nothing expected: status %0d credit %0d",
                   rsp_status, rsp_credit);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_credit !== want.credit) begin
               $error("credit: expected %0d, actual %0d", want.credit, rsp_credit);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      budget_per_tick = CPP_RESET;
      for (int k = 0; k < FLOWS; k++) begin
         flow_credit[k]   = '0;
         flow_weight[k]   = '0;
         flow_min_pct[k]  = 0;
         flow_max_pct[k]  = 0;
         flow_active[k]   = 1'b0;
         service_order[k] = 0;
      end
      order_len        = 0;
      weight_sum_model = 0;
      leftover_pool    = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_budget_and_idling();
      test_backpressure();
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
